// File: design/ngs_pkg.sv
package ngs_pkg;

  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_STEP = 1'b1;

  localparam logic CFG_GRAVITY = 1'b0;
  localparam logic CFG_ACTIVE  = 1'b1;

  localparam logic [63:0] EPS_Q32     = 64'd429497;
  localparam logic [64:0] CONTRIB_CAP = 65'h100_0000_0000;
  localparam logic [31:0] FRAC_ONE    = 32'h8000_0000;

  localparam logic [6:0] MUL_STEPS  = 7'd32;
  localparam logic [6:0] DIV_STEPS  = 7'd80;
  localparam logic [6:0] SQRT_STEPS = 7'd32;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_e;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic [79:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [95:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic               opcode;
    logic [2:0]         body_index;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic [30:0]        load_mass;
    logic [30:0]        time_step;
    logic               hold_enable;
    logic [2:0]         hold_index;
  } in_t;

  typedef struct packed {
    logic [2:0]         out_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic               last_body;
  } out_t;

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// File: design/ngs_alu.sv
module ngs_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ngs_pkg::alu_req_t req_i,
  output ngs_pkg::alu_rsp_t rsp_o
);
  import ngs_pkg::*;

  alu_op_e     op_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [79:0] x_q, x_d;
  logic [64:0] y_q, y_d;
  logic [63:0] z_q, z_d;

  logic [64:0] msum, dt_v;
  logic [35:0] sr, strial;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    msum   = {1'b0, y_q[63:0]} + (x_q[0] ? {1'b0, z_q} : 65'd0);
    dt_v   = {y_q[63:0], x_q[79]};
    sr     = {y_q[33:0], x_q[63:62]};
    strial = {2'b00, z_q[31:0], 2'b01};
    case (op_q)
      OP_MUL: begin
        y_d = {1'b0, msum[64:1]};
        x_d = {48'd0, msum[0], x_q[31:1]};
      end
      OP_DIV: begin
        if (dt_v >= {1'b0, z_q}) begin
          y_d = dt_v - {1'b0, z_q};
          x_d = {x_q[78:0], 1'b1};
        end else begin
          y_d = dt_v;
          x_d = {x_q[78:0], 1'b0};
        end
      end
      OP_SQRT: begin
        if (sr >= strial) begin
          y_d = {29'd0, sr - strial};
          z_d = {z_q[62:0], 1'b1};
        end else begin
          y_d = {29'd0, sr};
          z_d = {z_q[62:0], 1'b0};
        end
        x_d = {x_q[77:0], 2'b00};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= busy_q && (cnt_q == 7'd1);
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        case (req_i.op)
          OP_MUL:  cnt_q <= MUL_STEPS;
          OP_DIV:  cnt_q <= DIV_STEPS;
          default: cnt_q <= SQRT_STEPS;
        endcase
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      y_q <= '0;
      case (req_i.op)
        OP_MUL: begin
          x_q <= {48'd0, req_i.b[31:0]};
          z_q <= req_i.a[63:0];
        end
        OP_DIV: begin
          x_q <= req_i.a;
          z_q <= req_i.b;
        end
        default: begin
          x_q <= req_i.a;
          z_q <= '0;
        end
      endcase
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    case (op_q)
      OP_MUL:  rsp_o.result = {y_q[63:0], x_q[31:0]};
      OP_DIV:  rsp_o.result = {16'd0, x_q};
      default: rsp_o.result = {64'd0, z_q[31:0]};
    endcase
  end

endmodule

// File: design/nbody_gravity_step.sv
// channel | dir | handshake                  | beat
// in      | in  | in_valid_i / in_ready_o    | in_data_i  (load or step item)
// out     | out | out_valid_o / out_ready_i  | out_data_o (one body per beat)
// cfg     | in  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
// a load is written into the body registers from idle; a step works each body pair
// and then each active body through one shared bit-serial multiply, divide and
// square-root unit (32, 80 and 32 iterations per operation)
// in_ready_o is high only when idle; each result beat holds until out_ready_i
// reset clears all bodies, gravity_constant to 1.0 and active_count to 8
module nbody_gravity_step #(
  parameter int MAX_BODIES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ngs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ngs_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [30:0]   cfg_data_i
);
  import ngs_pkg::*;

  localparam int IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CW = $clog2(MAX_BODIES + 1);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_FI   = 5'd1;
  localparam logic [4:0] ST_FJ   = 5'd2;
  localparam logic [4:0] ST_SQX  = 5'd3;
  localparam logic [4:0] ST_SQY  = 5'd4;
  localparam logic [4:0] ST_SQRT = 5'd5;
  localparam logic [4:0] ST_GMJ  = 5'd6;
  localparam logic [4:0] ST_DIVI = 5'd7;
  localparam logic [4:0] ST_GMI  = 5'd8;
  localparam logic [4:0] ST_DIVJ = 5'd9;
  localparam logic [4:0] ST_FX   = 5'd10;
  localparam logic [4:0] ST_FY   = 5'd11;
  localparam logic [4:0] ST_CXI  = 5'd12;
  localparam logic [4:0] ST_CYI  = 5'd13;
  localparam logic [4:0] ST_CXJ  = 5'd14;
  localparam logic [4:0] ST_CYJ  = 5'd15;
  localparam logic [4:0] ST_VX   = 5'd16;
  localparam logic [4:0] ST_VY   = 5'd17;
  localparam logic [4:0] ST_PX   = 5'd18;
  localparam logic [4:0] ST_PY   = 5'd19;
  localparam logic [4:0] ST_EMIT = 5'd20;

  logic signed [31:0] pos_x_q [MAX_BODIES];
  logic signed [31:0] pos_y_q [MAX_BODIES];
  logic signed [31:0] vel_x_q [MAX_BODIES];
  logic signed [31:0] vel_y_q [MAX_BODIES];
  logic signed [31:0] acc_x_q [MAX_BODIES];
  logic signed [31:0] acc_y_q [MAX_BODIES];
  logic [30:0]        mass_q  [MAX_BODIES];

  logic [4:0]    state_q, state_d;
  logic          go_q, go_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, b_q, b_d, n_q, n_d, n_eff;
  logic [30:0]   grav_q;
  logic [3:0]    active_q;

  logic signed [31:0] pxi_q, pxi_d, pyi_q, pyi_d;
  logic [30:0]   mi_q, mi_d, mj_q, mj_d, dt_q, dt_d;
  logic          dxn_q, dxn_d, dyn_q, dyn_d, hold_q, hold_d;
  logic [2:0]    hidx_q, hidx_d;
  logic [31:0]   ax_q, ax_d, ay_q, ay_d, d_q, d_d, fx_q, fx_d, fy_q, fy_d;
  logic [63:0]   s_q, s_d, ai_q, ai_d, aj_q, aj_d;

  logic [IW-1:0] rd;
  logic signed [31:0] c_px, c_py, c_vx, c_vy, c_ax, c_ay;
  logic [30:0]   c_m;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic        in_acc, ld_we, acc_clr;
  logic        accx_we, accy_we, velx_we, vely_we, posx_we, posy_we;
  logic signed [31:0] acc_wv, int_wv;
  logic signed [32:0] dx, dy;
  logic [64:0] sq_sum, sq_eps, pull_t;
  logic [63:0] sq_sat;
  logic [40:0] pull_c;
  logic        pull_sub, int_neg;
  logic signed [31:0] pull_base, int_base;
  logic signed [63:0] pull_sum, int_sp, int_sum;
  logic [63:0] int_prod;
  logic [CW:0] j_inc, i_inc2, b_inc;

  ngs_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    if (active_q == 4'd0) begin
      n_eff = CW'(1);
    end else if (32'(active_q) > 32'(MAX_BODIES)) begin
      n_eff = CW'(MAX_BODIES);
    end else begin
      n_eff = CW'(active_q);
    end
  end

  always_comb begin
    case (state_q)
      ST_FI, ST_CXI, ST_CYI: rd = IW'(i_q);
      ST_FJ, ST_CXJ, ST_CYJ: rd = IW'(j_q);
      default:               rd = IW'(b_q);
    endcase
  end

  assign c_px = pos_x_q[rd];
  assign c_py = pos_y_q[rd];
  assign c_vx = vel_x_q[rd];
  assign c_vy = vel_y_q[rd];
  assign c_ax = acc_x_q[rd];
  assign c_ay = acc_y_q[rd];
  assign c_m  = mass_q[rd];

  assign j_inc  = {1'b0, j_q} + (CW+1)'(1);
  assign i_inc2 = {1'b0, i_q} + (CW+1)'(2);
  assign b_inc  = {1'b0, b_q} + (CW+1)'(1);

  always_comb begin
    out_data_o.out_index = 3'(b_q);
    out_data_o.out_pos_x = c_px;
    out_data_o.out_pos_y = c_py;
    out_data_o.out_vel_x = c_vx;
    out_data_o.out_vel_y = c_vy;
    out_data_o.last_body = (b_inc == {1'b0, n_q});
  end

  // pair distance and softened square
  assign dx     = {pxi_q[31], pxi_q} - {c_px[31], c_px};
  assign dy     = {pyi_q[31], pyi_q} - {c_py[31], c_py};
  assign sq_sum = {1'b0, s_q} + {1'b0, alu_rsp.result[63:0]};
  assign sq_sat = sq_sum[64] ? '1 : sq_sum[63:0];
  assign sq_eps = {1'b0, sq_sat} + {1'b0, EPS_Q32};

  // pull on one axis
  assign pull_t    = alu_rsp.result[95:31];
  assign pull_c    = (pull_t > CONTRIB_CAP) ? CONTRIB_CAP[40:0] : pull_t[40:0];
  assign pull_base = (state_q == ST_CXI || state_q == ST_CXJ) ? c_ax : c_ay;
  always_comb begin
    case (state_q)
      ST_CXI:  pull_sub = !dxn_q;
      ST_CYI:  pull_sub = !dyn_q;
      ST_CXJ:  pull_sub = dxn_q;
      default: pull_sub = dyn_q;
    endcase
  end
  assign pull_sum = pull_sub ? (64'(pull_base) - $signed({23'd0, pull_c}))
                             : (64'(pull_base) + $signed({23'd0, pull_c}));
  assign acc_wv   = sat32(pull_sum);

  // integration
  always_comb begin
    case (state_q)
      ST_VX: begin
        int_base = c_vx;
        int_neg  = c_ax[31];
      end
      ST_VY: begin
        int_base = c_vy;
        int_neg  = c_ay[31];
      end
      ST_PX: begin
        int_base = c_px;
        int_neg  = c_vx[31];
      end
      default: begin
        int_base = c_py;
        int_neg  = c_vy[31];
      end
    endcase
  end
  assign int_prod = alu_rsp.result[63:0];
  assign int_sp   = int_neg ? $signed(~int_prod + 64'd1) : $signed(int_prod);
  assign int_sum  = 64'(int_base) + (int_sp >>> 16);
  assign int_wv   = sat32(int_sum);

  // operand select for the shared unit
  always_comb begin
    alu_req.start = go_q;
    alu_req.op    = OP_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    case (state_q)
      ST_SQX: begin
        alu_req.a = {48'd0, ax_q};
        alu_req.b = {32'd0, ax_q};
      end
      ST_SQY: begin
        alu_req.a = {48'd0, ay_q};
        alu_req.b = {32'd0, ay_q};
      end
      ST_SQRT: begin
        alu_req.op = OP_SQRT;
        alu_req.a  = {16'd0, s_q};
      end
      ST_GMJ: begin
        alu_req.a = {49'd0, grav_q};
        alu_req.b = {33'd0, mj_q};
      end
      ST_GMI: begin
        alu_req.a = {49'd0, grav_q};
        alu_req.b = {33'd0, mi_q};
      end
      ST_DIVI: begin
        alu_req.op = OP_DIV;
        alu_req.a  = {2'd0, ai_q[61:0], 16'd0};
        alu_req.b  = s_q;
      end
      ST_DIVJ: begin
        alu_req.op = OP_DIV;
        alu_req.a  = {2'd0, aj_q[61:0], 16'd0};
        alu_req.b  = s_q;
      end
      ST_FX: begin
        alu_req.op = OP_DIV;
        alu_req.a  = {17'd0, ax_q, 31'd0};
        alu_req.b  = {32'd0, d_q};
      end
      ST_FY: begin
        alu_req.op = OP_DIV;
        alu_req.a  = {17'd0, ay_q, 31'd0};
        alu_req.b  = {32'd0, d_q};
      end
      ST_CXI: begin
        alu_req.a = {16'd0, ai_q};
        alu_req.b = {32'd0, fx_q};
      end
      ST_CYI: begin
        alu_req.a = {16'd0, ai_q};
        alu_req.b = {32'd0, fy_q};
      end
      ST_CXJ: begin
        alu_req.a = {16'd0, aj_q};
        alu_req.b = {32'd0, fx_q};
      end
      ST_CYJ: begin
        alu_req.a = {16'd0, aj_q};
        alu_req.b = {32'd0, fy_q};
      end
      ST_VX: begin
        alu_req.a = {48'd0, abs32(c_ax)};
        alu_req.b = {33'd0, dt_q};
      end
      ST_VY: begin
        alu_req.a = {48'd0, abs32(c_ay)};
        alu_req.b = {33'd0, dt_q};
      end
      ST_PX: begin
        alu_req.a = {48'd0, abs32(c_vx)};
        alu_req.b = {33'd0, dt_q};
      end
      ST_PY: begin
        alu_req.a = {48'd0, abs32(c_vy)};
        alu_req.b = {33'd0, dt_q};
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; b_d = b_q; n_d = n_q;
    pxi_d = pxi_q; pyi_d = pyi_q; mi_d = mi_q; mj_d = mj_q;
    dxn_d = dxn_q; dyn_d = dyn_q; ax_d = ax_q; ay_d = ay_q;
    s_d = s_q; d_d = d_q; ai_d = ai_q; aj_d = aj_q; fx_d = fx_q; fy_d = fy_q;
    dt_d = dt_q; hold_d = hold_q; hidx_d = hidx_q;
    ld_we = 1'b0; acc_clr = 1'b0;
    accx_we = 1'b0; accy_we = 1'b0;
    velx_we = 1'b0; vely_we = 1'b0; posx_we = 1'b0; posy_we = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.opcode == OPC_LOAD) begin
            ld_we = 32'(in_data_i.body_index) < 32'(MAX_BODIES);
          end else begin
            acc_clr = 1'b1;
            dt_d    = in_data_i.time_step;
            hold_d  = in_data_i.hold_enable;
            hidx_d  = in_data_i.hold_index;
            n_d     = n_eff;
            i_d     = '0;
            j_d     = CW'(1);
            b_d     = '0;
            if (n_eff == CW'(1)) begin
              state_d = (in_data_i.hold_enable && in_data_i.hold_index == 3'd0)
                        ? ST_EMIT : ST_VX;
            end else begin
              state_d = ST_FI;
            end
          end
        end
      end
      ST_FI: begin
        pxi_d   = c_px;
        pyi_d   = c_py;
        mi_d    = c_m;
        state_d = ST_FJ;
      end
      ST_FJ: begin
        mj_d    = c_m;
        dxn_d   = dx[32];
        dyn_d   = dy[32];
        ax_d    = dx[32] ? 32'(-dx) : dx[31:0];
        ay_d    = dy[32] ? 32'(-dy) : dy[31:0];
        state_d = ST_SQX;
      end
      ST_SQX: if (alu_rsp.done) begin
        s_d     = alu_rsp.result[63:0];
        state_d = ST_SQY;
      end
      ST_SQY: if (alu_rsp.done) begin
        s_d     = sq_eps[64] ? '1 : sq_eps[63:0];
        state_d = ST_SQRT;
      end
      ST_SQRT: if (alu_rsp.done) begin
        d_d     = alu_rsp.result[31:0];
        state_d = ST_GMJ;
      end
      ST_GMJ: if (alu_rsp.done) begin
        ai_d    = alu_rsp.result[63:0];
        state_d = ST_DIVI;
      end
      ST_DIVI: if (alu_rsp.done) begin
        ai_d    = alu_rsp.result[63:0];
        state_d = ST_GMI;
      end
      ST_GMI: if (alu_rsp.done) begin
        aj_d    = alu_rsp.result[63:0];
        state_d = ST_DIVJ;
      end
      ST_DIVJ: if (alu_rsp.done) begin
        aj_d    = alu_rsp.result[63:0];
        state_d = ST_FX;
      end
      ST_FX: if (alu_rsp.done) begin
        fx_d = (alu_rsp.result[79:32] != '0 ||
                (alu_rsp.result[31] && alu_rsp.result[30:0] != '0))
               ? FRAC_ONE : alu_rsp.result[31:0];
        state_d = ST_FY;
      end
      ST_FY: if (alu_rsp.done) begin
        fy_d = (alu_rsp.result[79:32] != '0 ||
                (alu_rsp.result[31] && alu_rsp.result[30:0] != '0))
               ? FRAC_ONE : alu_rsp.result[31:0];
        state_d = ST_CXI;
      end
      ST_CXI: if (alu_rsp.done) begin
        accx_we = 1'b1;
        state_d = ST_CYI;
      end
      ST_CYI: if (alu_rsp.done) begin
        accy_we = 1'b1;
        state_d = ST_CXJ;
      end
      ST_CXJ: if (alu_rsp.done) begin
        accx_we = 1'b1;
        state_d = ST_CYJ;
      end
      ST_CYJ: if (alu_rsp.done) begin
        accy_we = 1'b1;
        if (j_inc < {1'b0, n_q}) begin
          j_d     = CW'(j_inc);
          state_d = ST_FI;
        end else if (i_inc2 < {1'b0, n_q}) begin
          i_d     = i_q + CW'(1);
          j_d     = CW'(i_inc2);
          state_d = ST_FI;
        end else begin
          b_d     = '0;
          state_d = (hold_q && hidx_q == 3'd0) ? ST_EMIT : ST_VX;
        end
      end
      ST_VX: if (alu_rsp.done) begin
        velx_we = 1'b1;
        state_d = ST_VY;
      end
      ST_VY: if (alu_rsp.done) begin
        vely_we = 1'b1;
        state_d = ST_PX;
      end
      ST_PX: if (alu_rsp.done) begin
        posx_we = 1'b1;
        state_d = ST_PY;
      end
      ST_PY: if (alu_rsp.done) begin
        posy_we = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: if (out_ready_i) begin
        if (b_inc < {1'b0, n_q}) begin
          b_d     = CW'(b_inc);
          state_d = (hold_q && 32'(b_inc) == 32'(hidx_q)) ? ST_EMIT : ST_VX;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign go_d = (state_d != state_q) && !(state_d == ST_IDLE || state_d == ST_FI ||
                state_d == ST_FJ || state_d == ST_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      go_q     <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      b_q      <= '0;
      n_q      <= '0;
      grav_q   <= 31'd65536;
      active_q <= 4'd8;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      i_q     <= i_d;
      j_q     <= j_d;
      b_q     <= b_d;
      n_q     <= n_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_GRAVITY) begin
          grav_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_ACTIVE) begin
          active_q <= cfg_data_i[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pxi_q <= pxi_d; pyi_q <= pyi_d; mi_q <= mi_d; mj_q <= mj_d;
    dxn_q <= dxn_d; dyn_q <= dyn_d; ax_q <= ax_d; ay_q <= ay_d;
    s_q <= s_d; d_q <= d_d; ai_q <= ai_d; aj_q <= aj_d; fx_q <= fx_d; fy_q <= fy_d;
    dt_q <= dt_d; hold_q <= hold_d; hidx_q <= hidx_d;
  end

  // body state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_BODIES; k++) begin
        pos_x_q[k] <= '0;
        pos_y_q[k] <= '0;
        vel_x_q[k] <= '0;
        vel_y_q[k] <= '0;
        acc_x_q[k] <= '0;
        acc_y_q[k] <= '0;
        mass_q[k]  <= '0;
      end
    end else begin
      if (ld_we) begin
        pos_x_q[IW'(in_data_i.body_index)] <= in_data_i.load_pos_x;
        pos_y_q[IW'(in_data_i.body_index)] <= in_data_i.load_pos_y;
        vel_x_q[IW'(in_data_i.body_index)] <= in_data_i.load_vel_x;
        vel_y_q[IW'(in_data_i.body_index)] <= in_data_i.load_vel_y;
        mass_q[IW'(in_data_i.body_index)]  <= in_data_i.load_mass;
      end
      if (acc_clr) begin
        for (int k = 0; k < MAX_BODIES; k++) begin
          acc_x_q[k] <= '0;
          acc_y_q[k] <= '0;
        end
      end
      if (accx_we) begin
        acc_x_q[rd] <= acc_wv;
      end
      if (accy_we) begin
        acc_y_q[rd] <= acc_wv;
      end
      if (velx_we) begin
        vel_x_q[rd] <= int_wv;
      end
      if (vely_we) begin
        vel_y_q[rd] <= int_wv;
      end
      if (posx_we) begin
        pos_x_q[rd] <= int_wv;
      end
      if (posy_we) begin
        pos_y_q[rd] <= int_wv;
      end
    end
  end

endmodule
